### hw/rtl/calendar_date_arithmetic_unit_core_defines.svh
// ----------------------------------------------------------------------------
// Calendar date arithmetic unit - assertion macros
// Shared property forms for the checks at the end of the core.
// ----------------------------------------------------------------------------
`ifndef CALENDAR_DATE_ARITHMETIC_UNIT_CORE_DEFINES_SVH
`define CALENDAR_DATE_ARITHMETIC_UNIT_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CDAU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cdau same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CDAU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cdau next-cycle check failed");

`endif

### hw/rtl/cdau_pkg.sv
// ----------------------------------------------------------------------------
// Calendar date arithmetic unit - package
// Codes, sequencer states and calendar helper functions.
// ----------------------------------------------------------------------------
package cdau_pkg;

    localparam logic [13:0] YEAR_MAX    = 14'd9999;
    localparam int          OUT_TDATA_W = 56;

    typedef enum logic [1:0] {
        OP_ADD     = 2'd0,
        OP_SUB     = 2'd1,
        OP_DIFF    = 2'd2,
        OP_WEEKDAY = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_BAD_DATE = 2'd1,
        STAT_RANGE    = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DAY_ADD,
        ST_DAY_SUB,
        ST_DAY_FIX,
        ST_YEAR_MOVE,
        ST_YEAR_CLAMP,
        ST_DIFF_ACC,
        ST_WEEK_MOD,
        ST_DONE
    } t_state;

    // day-number terms, accumulated one per cycle
    localparam logic [2:0] TERM_YEARS  = 3'd0;
    localparam logic [2:0] TERM_DIV4   = 3'd1;
    localparam logic [2:0] TERM_DIV100 = 3'd2;
    localparam logic [2:0] TERM_DIV400 = 3'd3;
    localparam logic [2:0] TERM_CUM    = 3'd4;

    typedef struct packed {
        logic neg;
        logic zero;
    } t_alu_flags;

    // y / 100 by reciprocal, exact for any 14-bit y
    function automatic logic [7:0] div100(input logic [13:0] y);
        logic [26:0] prod;
        prod = {13'd0, y} * 27'd5243;
        return prod[26:19];
    endfunction

    function automatic logic is_leap(input logic [13:0] y);
        logic [7:0]  q;
        logic [14:0] q100;
        q    = div100(y);
        q100 = {7'd0, q} * 15'd100;
        return (y[1:0] == 2'b00) && ((q100 != {1'b0, y}) || (q[1:0] == 2'b00));
    endfunction

    // zero for a month outside 1..12
    function automatic logic [4:0] days_in(input logic [3:0] m, input logic [13:0] y);
        logic [4:0] n;
        case (m)
            4'd2: begin
                n = is_leap(y) ? 5'd29 : 5'd28;
            end
            4'd4, 4'd6, 4'd9, 4'd11: begin
                n = 5'd30;
            end
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: begin
                n = 5'd31;
            end
            default: begin
                n = 5'd0;
            end
        endcase
        return n;
    endfunction

    function automatic logic valid_date(input logic [13:0] y, input logic [3:0] m,
                                        input logic [4:0] d);
        logic [4:0] dim;
        dim = days_in(m, y);
        return (y != 14'd0) && (y <= YEAR_MAX) && (dim != 5'd0) &&
               (d != 5'd0) && (d <= dim);
    endfunction

    // days before the first of month m in a common year
    function automatic logic [8:0] cum_days(input logic [3:0] m);
        logic [8:0] c;
        case (m)
            4'd1:    c = 9'd0;
            4'd2:    c = 9'd31;
            4'd3:    c = 9'd59;
            4'd4:    c = 9'd90;
            4'd5:    c = 9'd120;
            4'd6:    c = 9'd151;
            4'd7:    c = 9'd181;
            4'd8:    c = 9'd212;
            4'd9:    c = 9'd243;
            4'd10:   c = 9'd273;
            4'd11:   c = 9'd304;
            4'd12:   c = 9'd334;
            default: c = 9'd0;
        endcase
        return c;
    endfunction

    function automatic logic [2:0] wd_month(input logic [3:0] m);
        logic [2:0] t;
        case (m)
            4'd1:    t = 3'd0;
            4'd2:    t = 3'd3;
            4'd3:    t = 3'd3;
            4'd4:    t = 3'd6;
            4'd5:    t = 3'd1;
            4'd6:    t = 3'd4;
            4'd7:    t = 3'd6;
            4'd8:    t = 3'd2;
            4'd9:    t = 3'd5;
            4'd10:   t = 3'd0;
            4'd11:   t = 3'd3;
            4'd12:   t = 3'd5;
            default: t = 3'd0;
        endcase
        return t;
    endfunction

    // x % 7 by reciprocal; exact for x up to 200, weekday sums stay below 167
    function automatic logic [2:0] mod7(input logic [7:0] x);
        logic [15:0] p;
        logic [8:0]  q7;
        logic [7:0]  r;
        p  = {8'd0, x} * 16'd147;
        q7 = {3'd0, p[15:10]} * 9'd7;
        r  = x - q7[7:0];
        return r[2:0];
    endfunction

endpackage

### hw/rtl/cdau_alu.sv
// ----------------------------------------------------------------------------
// Calendar date arithmetic unit - shared adder
// Add/subtract with sign and zero flags, reused by the sequencer steps.
// ----------------------------------------------------------------------------
module cdau_alu #(
    parameter int W = 24
) (
    input  logic [W-1:0]          i_a,
    input  logic [W-1:0]          i_b,
    input  logic                  i_sub,
    output logic [W-1:0]          o_sum,
    output cdau_pkg::t_alu_flags  o_flags
);

    logic [W-1:0] w_b;

    assign w_b           = i_sub ? ~i_b : i_b;
    assign o_sum         = i_a + w_b + W'(i_sub);
    // operands stay below 2**(W-2), so the top bit is the sign
    assign o_flags.neg   = o_sum[W-1];
    assign o_flags.zero  = (o_sum == '0);

endmodule

### hw/rtl/calendar_date_arithmetic_unit_core.sv
// ----------------------------------------------------------------------------
// Calendar date arithmetic unit - core
// Gregorian date add/subtract, difference/compare and weekday.
// ----------------------------------------------------------------------------
// One request is taken at a time; s_axis_tready is high only while the core
// is idle. After acceptance the check state validates the dates, then the
// sequencer drives a single shared adder: day add and day subtract step one
// month per cycle, year moves use the move and clamp states, and day
// difference sums the day-number terms of both dates. The result sits in an
// output register, so the next request is taken while a result waits; a new
// result waits in the last step until that register is free. arith_mode is
// written on the cfg channel (always ready).
`include "calendar_date_arithmetic_unit_core_defines.svh"

module calendar_date_arithmetic_unit_core #(
    parameter int AMOUNT_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // year_a[13:0] month_a[17:14] day_a[22:18] year_b[36:23] month_b[40:37]
    // day_b[45:41] amount[46+:AMOUNT_BITS], zero pad to bytes
    input  logic [((46+AMOUNT_BITS+7)/8)*8-1:0] s_axis_tdata,
    // op[1:0]
    input  logic [1:0]                           s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // res_year[13:0] res_month[17:14] res_day[22:18] difference[45:23]
    // a_is_later[46] dates_equal[47] weekday[50:48], zero pad [55:51]
    output logic [cdau_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // status[1:0]
    output logic [1:0]                           m_axis_tuser,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic                                 i_cfg_data
);

    localparam int DW = AMOUNT_BITS + 1;
    localparam int AW = (AMOUNT_BITS + 2 > 24) ? AMOUNT_BITS + 2 : 24;

    // request payload
    cdau_pkg::t_op            r_op;
    logic [13:0]              r_ya, r_yb;
    logic [3:0]               r_ma, r_mb;
    logic [4:0]               r_da, r_db;
    logic [AMOUNT_BITS-1:0]   r_amt;

    // control
    cdau_pkg::t_state         r_state, n_state;
    logic                     r_arith_mode;
    logic                     r_out_valid;
    logic [cdau_pkg::OUT_TDATA_W-1:0] r_out_data;
    logic [1:0]               r_out_user;

    // working registers
    logic [13:0]              r_y, n_y;
    logic [3:0]               r_m, n_m;
    logic [DW-1:0]            r_d, n_d;
    logic [AMOUNT_BITS-1:0]   r_left, n_left;
    logic [AW-1:0]            r_acc, n_acc;
    logic [2:0]               r_step, n_step;
    logic                     r_side, n_side;
    logic                     r_later, n_later;
    logic                     r_equal, n_equal;
    logic [2:0]               r_wd, n_wd;
    cdau_pkg::t_status        r_status, n_status;

    // shared adder
    logic [AW-1:0]            w_alu_a, w_alu_b, w_alu_sum;
    logic                     w_alu_sub;
    cdau_pkg::t_alu_flags     w_alu_flags;

    logic                     w_accept;
    logic                     w_in_ok;
    logic                     w_later, w_equal, w_corr;
    logic                     w_more, w_year_bad;
    logic [3:0]               w_prev_m, w_dim_m;
    logic [13:0]              w_prev_y, w_dim_y;
    logic [4:0]               w_dim;

    // day-number terms
    logic [13:0]              w_dy, w_ly;
    logic [3:0]               w_dm;
    logic [4:0]               w_dd;
    logic [7:0]               w_q;
    logic [22:0]              w_y365;
    logic [9:0]               w_cum_d;
    logic [AW-1:0]            w_term;
    logic                     w_term_sub;

    // weekday terms
    logic [7:0]               w_qa;
    logic [14:0]              w_qa100;
    logic [6:0]               w_yy;
    logic [2:0]               w_cent, w_mt;
    logic [7:0]               w_wk_sum;

    // result fields
    logic                     w_date_ok, w_diff_ok, w_wd_ok;

    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == cdau_pkg::ST_IDLE);
    assign o_cfg_ready   = 1'b1;

    cdau_alu #(
        .W (AW)
    ) u_alu (
        .i_a     (w_alu_a),
        .i_b     (w_alu_b),
        .i_sub   (w_alu_sub),
        .o_sum   (w_alu_sum),
        .o_flags (w_alu_flags)
    );

    // ---------------- validation and compare ----------------
    assign w_in_ok = cdau_pkg::valid_date(r_ya, r_ma, r_da) &&
                     ((r_op != cdau_pkg::OP_DIFF) || cdau_pkg::valid_date(r_yb, r_mb, r_db));
    assign w_later = (r_ya > r_yb) ||
                     ((r_ya == r_yb) && ((r_ma > r_mb) || ((r_ma == r_mb) && (r_da > r_db))));
    assign w_equal = (r_ya == r_yb) && (r_ma == r_mb) && (r_da == r_db);
    // anniversary not yet reached
    assign w_corr  = (r_mb > r_ma) || ((r_mb == r_ma) && (r_db > r_da));

    // ---------------- month stepping ----------------
    assign w_more     = !w_alu_flags.neg && !w_alu_flags.zero;
    assign w_prev_m   = (r_m == 4'd1) ? 4'd12 : r_m - 4'd1;
    assign w_prev_y   = (r_m == 4'd1) ? r_y - 14'd1 : r_y;
    assign w_year_bad = (r_op == cdau_pkg::OP_SUB) ? (w_alu_flags.neg || w_alu_flags.zero)
                                                   : (w_alu_sum > AW'(cdau_pkg::YEAR_MAX));

    // one month-length lookup, shared by the month stepping and year clamp states
    always_comb begin
        case (r_state)
            cdau_pkg::ST_DAY_SUB: begin
                w_dim_m = w_prev_m;
                w_dim_y = w_prev_y;
            end
            cdau_pkg::ST_YEAR_CLAMP: begin
                w_dim_m = r_ma;
                w_dim_y = r_y;
            end
            default: begin
                w_dim_m = r_m;
                w_dim_y = r_y;
            end
        endcase
    end
    assign w_dim = cdau_pkg::days_in(w_dim_m, w_dim_y);

    // ---------------- day number ----------------
    assign w_dy    = r_side ? r_yb : r_ya;
    assign w_dm    = r_side ? r_mb : r_ma;
    assign w_dd    = r_side ? r_db : r_da;
    // leap days counted through the previous year before March
    assign w_ly    = (w_dm > 4'd2) ? w_dy : w_dy - 14'd1;
    assign w_q     = cdau_pkg::div100(w_ly);
    assign w_y365  = {9'd0, w_dy} * 23'd365;
    assign w_cum_d = {1'b0, cdau_pkg::cum_days(w_dm)} + {5'd0, w_dd};

    always_comb begin
        case (r_step)
            cdau_pkg::TERM_YEARS:  w_term = AW'(w_y365);
            cdau_pkg::TERM_DIV4:   w_term = AW'(w_ly[13:2]);
            cdau_pkg::TERM_DIV100: w_term = AW'(w_q);
            cdau_pkg::TERM_DIV400: w_term = AW'(w_q[7:2]);
            cdau_pkg::TERM_CUM:    w_term = AW'(w_cum_d);
            default:               w_term = '0;
        endcase
    end
    assign w_term_sub = r_side ^ (r_step == cdau_pkg::TERM_DIV100);

    // ---------------- weekday ----------------
    assign w_qa     = cdau_pkg::div100(r_ya);
    assign w_qa100  = {7'd0, w_qa} * 15'd100;
    assign w_yy     = 7'(r_ya - w_qa100[13:0]);
    assign w_cent   = {2'd3 - w_qa[1:0], 1'b0};
    always_comb begin
        w_mt = cdau_pkg::wd_month(r_ma);
        if (cdau_pkg::is_leap(r_ya) && (r_ma == 4'd1)) begin
            w_mt = 3'd6;
        end else if (cdau_pkg::is_leap(r_ya) && (r_ma == 4'd2)) begin
            w_mt = 3'd2;
        end
    end
    assign w_wk_sum = 8'(w_cent) + 8'(w_yy) + 8'(w_yy[6:2]) + 8'(w_mt) + 8'(r_da);

    // ---------------- adder operands ----------------
    always_comb begin
        w_alu_a   = '0;
        w_alu_b   = '0;
        w_alu_sub = 1'b0;
        case (r_state)
            cdau_pkg::ST_CHECK: begin
                if (r_op == cdau_pkg::OP_DIFF) begin
                    w_alu_a   = AW'(r_ya);
                    w_alu_b   = AW'(r_yb) + AW'(w_corr);
                    w_alu_sub = 1'b1;
                end else begin
                    w_alu_a   = AW'(r_da);
                    w_alu_b   = AW'(r_amt);
                end
            end
            cdau_pkg::ST_DAY_ADD: begin
                w_alu_a   = AW'(r_d);
                w_alu_b   = AW'(w_dim);
                w_alu_sub = 1'b1;
            end
            cdau_pkg::ST_DAY_SUB: begin
                w_alu_a   = AW'(r_left);
                w_alu_b   = AW'(r_d);
                w_alu_sub = 1'b1;
            end
            cdau_pkg::ST_DAY_FIX: begin
                w_alu_a   = AW'(r_d);
                w_alu_b   = AW'(r_left);
                w_alu_sub = 1'b1;
            end
            cdau_pkg::ST_YEAR_MOVE: begin
                w_alu_a   = AW'(r_ya);
                w_alu_b   = AW'(r_amt);
                w_alu_sub = (r_op == cdau_pkg::OP_SUB);
            end
            cdau_pkg::ST_DIFF_ACC: begin
                w_alu_a   = r_acc;
                w_alu_b   = w_term;
                w_alu_sub = w_term_sub;
            end
            default: begin
                w_alu_sub = 1'b0;
            end
        endcase
    end

    // ---------------- sequencer: next state ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            cdau_pkg::ST_IDLE: begin
                if (s_axis_tvalid) n_state = cdau_pkg::ST_CHECK;
            end
            cdau_pkg::ST_CHECK: begin
                if (!w_in_ok) begin
                    n_state = cdau_pkg::ST_DONE;
                end else begin
                    case (r_op)
                        cdau_pkg::OP_ADD: begin
                            n_state = r_arith_mode ? cdau_pkg::ST_YEAR_MOVE
                                                   : cdau_pkg::ST_DAY_ADD;
                        end
                        cdau_pkg::OP_SUB: begin
                            n_state = r_arith_mode ? cdau_pkg::ST_YEAR_MOVE
                                                   : cdau_pkg::ST_DAY_SUB;
                        end
                        cdau_pkg::OP_DIFF: begin
                            n_state = r_arith_mode ? cdau_pkg::ST_DONE
                                                   : cdau_pkg::ST_DIFF_ACC;
                        end
                        default: begin
                            n_state = cdau_pkg::ST_WEEK_MOD;
                        end
                    endcase
                end
            end
            cdau_pkg::ST_DAY_ADD: begin
                if (!w_more || ((r_m == 4'd12) && (r_y == cdau_pkg::YEAR_MAX))) begin
                    n_state = cdau_pkg::ST_DONE;
                end
            end
            cdau_pkg::ST_DAY_SUB: begin
                if (w_alu_flags.neg) begin
                    n_state = cdau_pkg::ST_DAY_FIX;
                end else if ((r_m == 4'd1) && (r_y == 14'd1)) begin
                    n_state = cdau_pkg::ST_DONE;
                end
            end
            cdau_pkg::ST_DAY_FIX: begin
                n_state = cdau_pkg::ST_DONE;
            end
            cdau_pkg::ST_YEAR_MOVE: begin
                n_state = w_year_bad ? cdau_pkg::ST_DONE : cdau_pkg::ST_YEAR_CLAMP;
            end
            cdau_pkg::ST_YEAR_CLAMP: begin
                n_state = cdau_pkg::ST_DONE;
            end
            cdau_pkg::ST_DIFF_ACC: begin
                if (r_side && (r_step == cdau_pkg::TERM_CUM)) n_state = cdau_pkg::ST_DONE;
            end
            cdau_pkg::ST_WEEK_MOD: begin
                n_state = cdau_pkg::ST_DONE;
            end
            cdau_pkg::ST_DONE: begin
                if (!r_out_valid || m_axis_tready) n_state = cdau_pkg::ST_IDLE;
            end
            default: begin
                n_state = cdau_pkg::ST_IDLE;
            end
        endcase
    end

    // ---------------- sequencer: datapath updates ----------------
    always_comb begin
        n_y      = r_y;
        n_m      = r_m;
        n_d      = r_d;
        n_left   = r_left;
        n_acc    = r_acc;
        n_step   = r_step;
        n_side   = r_side;
        n_later  = r_later;
        n_equal  = r_equal;
        n_wd     = r_wd;
        n_status = r_status;
        case (r_state)
            cdau_pkg::ST_CHECK: begin
                n_status = w_in_ok ? cdau_pkg::STAT_OK : cdau_pkg::STAT_BAD_DATE;
                n_later  = w_later;
                n_equal  = w_equal;
                n_y      = r_ya;
                n_m      = r_ma;
                n_d      = DW'(r_da);
                n_left   = r_amt;
                n_acc    = '0;
                n_step   = cdau_pkg::TERM_YEARS;
                n_side   = 1'b0;
                if ((r_op == cdau_pkg::OP_ADD) && !r_arith_mode) begin
                    n_d = w_alu_sum[DW-1:0];
                end else if ((r_op == cdau_pkg::OP_DIFF) && r_arith_mode) begin
                    n_acc = w_alu_sum;
                end else if (r_op == cdau_pkg::OP_WEEKDAY) begin
                    n_d = DW'(w_wk_sum);
                end
            end
            cdau_pkg::ST_DAY_ADD: begin
                if (w_more) begin
                    n_d = w_alu_sum[DW-1:0];
                    if (r_m == 4'd12) begin
                        if (r_y == cdau_pkg::YEAR_MAX) begin
                            n_status = cdau_pkg::STAT_RANGE;
                        end else begin
                            n_m = 4'd1;
                            n_y = r_y + 14'd1;
                        end
                    end else begin
                        n_m = r_m + 4'd1;
                    end
                end
            end
            cdau_pkg::ST_DAY_SUB: begin
                // whole current day-of-month consumed: back up to the previous month end
                if (!w_alu_flags.neg) begin
                    n_left = w_alu_sum[AMOUNT_BITS-1:0];
                    if ((r_m == 4'd1) && (r_y == 14'd1)) begin
                        n_status = cdau_pkg::STAT_RANGE;
                    end else begin
                        n_m = w_prev_m;
                        n_y = w_prev_y;
                        n_d = DW'(w_dim);
                    end
                end
            end
            cdau_pkg::ST_DAY_FIX: begin
                n_d = w_alu_sum[DW-1:0];
            end
            cdau_pkg::ST_YEAR_MOVE: begin
                if (w_year_bad) begin
                    n_status = cdau_pkg::STAT_RANGE;
                end else begin
                    n_y = w_alu_sum[13:0];
                end
            end
            cdau_pkg::ST_YEAR_CLAMP: begin
                // Feb 29 moved into a common year lands on Feb 28
                n_d = (r_da > w_dim) ? DW'(w_dim) : DW'(r_da);
            end
            cdau_pkg::ST_DIFF_ACC: begin
                n_acc = w_alu_sum;
                if (r_step == cdau_pkg::TERM_CUM) begin
                    n_step = cdau_pkg::TERM_YEARS;
                    n_side = 1'b1;
                end else begin
                    n_step = r_step + 3'd1;
                end
            end
            cdau_pkg::ST_WEEK_MOD: begin
                n_wd = cdau_pkg::mod7(r_d[7:0]);
            end
            default: begin
                n_wd = r_wd;
            end
        endcase
    end

    // ---------------- result assembly ----------------
    assign w_date_ok = (r_status == cdau_pkg::STAT_OK) &&
                       ((r_op == cdau_pkg::OP_ADD) || (r_op == cdau_pkg::OP_SUB));
    assign w_diff_ok = (r_status == cdau_pkg::STAT_OK) && (r_op == cdau_pkg::OP_DIFF);
    assign w_wd_ok   = (r_status == cdau_pkg::STAT_OK) && (r_op == cdau_pkg::OP_WEEKDAY);

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= cdau_pkg::ST_IDLE;
            r_arith_mode <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) r_arith_mode <= i_cfg_data;
            if ((r_state == cdau_pkg::ST_DONE) && (!r_out_valid || m_axis_tready)) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op  <= cdau_pkg::t_op'(s_axis_tuser);
            r_ya  <= s_axis_tdata[13:0];
            r_ma  <= s_axis_tdata[17:14];
            r_da  <= s_axis_tdata[22:18];
            r_yb  <= s_axis_tdata[36:23];
            r_mb  <= s_axis_tdata[40:37];
            r_db  <= s_axis_tdata[45:41];
            r_amt <= s_axis_tdata[46 +: AMOUNT_BITS];
        end
        r_y      <= n_y;
        r_m      <= n_m;
        r_d      <= n_d;
        r_left   <= n_left;
        r_acc    <= n_acc;
        r_step   <= n_step;
        r_side   <= n_side;
        r_later  <= n_later;
        r_equal  <= n_equal;
        r_wd     <= n_wd;
        r_status <= n_status;
        if ((r_state == cdau_pkg::ST_DONE) && (!r_out_valid || m_axis_tready)) begin
            r_out_data <= {5'd0,
                           w_wd_ok   ? r_wd        : 3'd0,
                           w_diff_ok ? r_equal     : 1'b0,
                           w_diff_ok ? r_later     : 1'b0,
                           w_diff_ok ? r_acc[22:0] : 23'd0,
                           w_date_ok ? r_d[4:0]    : 5'd0,
                           w_date_ok ? r_m         : 4'd0,
                           w_date_ok ? r_y         : 14'd0};
            r_out_user <= r_status;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

    // ---------------- assertions ----------------
    `CDAU_ASSERT_NEXT(a_busy_after_request, i_clk, i_rst_n, w_accept, !s_axis_tready)
    `CDAU_ASSERT_NOW(a_add_month_range, i_clk, i_rst_n, r_state == cdau_pkg::ST_DAY_ADD, (r_m >= 4'd1) && (r_m <= 4'd12))
    `CDAU_ASSERT_NOW(a_sub_day_range, i_clk, i_rst_n, r_state == cdau_pkg::ST_DAY_SUB, (r_d != '0) && (r_d <= DW'(31)))
    `CDAU_ASSERT_NOW(a_result_date_valid, i_clk, i_rst_n, (r_state == cdau_pkg::ST_DONE) && w_date_ok, cdau_pkg::valid_date(r_y, r_m, r_d[4:0]) && (r_d[DW-1:5] == '0))

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - calendar date arithmetic unit regression
// Drives directed and random date requests into the core in both arithmetic
// modes, with random gaps on the request stream and random stalls on the
// result stream, and checks every result against a hand-written expectation or a behavioral date calculator.
// ----------------------------------------------------------------------------
module tb_top;
    import cdau_pkg::*;

    localparam int AMOUNT_W = 16;
    localparam int IN_W     = ((46 + AMOUNT_W + 7) / 8) * 8;
    localparam int YEAR_TOP = 9999;

    localparam int MONTH_CUM [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
    localparam int WD_TAB [12]    = '{0, 3, 3, 6, 1, 4, 6, 2, 5, 0, 3, 5};

    typedef struct packed {
        t_op                 op;
        logic [13:0]         year_a;
        logic [3:0]          month_a;
        logic [4:0]          day_a;
        logic [13:0]         year_b;
        logic [3:0]          month_b;
        logic [4:0]          day_b;
        logic [AMOUNT_W-1:0] amount;
    } date_req_t;

    typedef struct packed {
        t_status     status;
        logic [2:0]  weekday;
        logic        dates_equal;
        logic        a_is_later;
        logic [22:0] difference;
        logic [4:0]  res_day;
        logic [3:0]  res_month;
        logic [13:0] res_year;
    } date_res_t;

    typedef struct {
        bit        mode;
        date_req_t req;
        bit        typed;
        date_res_t res;
    } dir_row_t;

    logic                               i_clk;
    logic                               i_rst_n;
    logic                               s_axis_tvalid;
    logic                               s_axis_tready;
    logic [IN_W-1:0]                    s_axis_tdata;
    logic [1:0]                         s_axis_tuser;
    logic                               m_axis_tvalid;
    logic                               m_axis_tready;
    logic [OUT_TDATA_W-1:0]             m_axis_tdata;
    logic [1:0]                         m_axis_tuser;
    logic                               i_cfg_valid;
    logic                               o_cfg_ready;
    logic                               i_cfg_data;

    date_res_t  due_results [$];
    dir_row_t   dir_tab [$];
    bit         arith_mode_q;
    bit         drain_hold_req;
    int         n_mismatch;

    calendar_date_arithmetic_unit_core #(
        .AMOUNT_BITS(AMOUNT_W)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ---------------- date calculator ----------------

    function automatic bit leap_year(int y);
        return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
    endfunction

    function automatic int month_days(int m, int y);
        case (m)
            2: begin
                return leap_year(y) ? 29 : 28;
            end
            4, 6, 9, 11: begin
                return 30;
            end
            1, 3, 5, 7, 8, 10, 12: begin
                return 31;
            end
            default: begin
                return 0;
            end
        endcase
    endfunction

    function automatic bit date_ok(int y, int m, int d);
        return (y >= 1) && (y <= YEAR_TOP) && (month_days(m, y) != 0) &&
               (d >= 1) && (d <= month_days(m, y));
    endfunction

    function automatic int serial_day(int y, int m, int d);
        int ly;
        ly = (m > 2) ? y : y - 1;
        return y * 365 + ly / 4 - ly / 100 + ly / 400 + MONTH_CUM[m - 1] + d;
    endfunction

    function automatic date_res_t compute_date_op(bit years, date_req_t r);
        int        y, m, d, left, diff, cent, yy, mt;
        date_res_t res;
        res = '0;
        y = int'(r.year_a);
        m = int'(r.month_a);
        d = int'(r.day_a);
        if (!date_ok(y, m, d) ||
            (r.op == OP_DIFF && !date_ok(int'(r.year_b), int'(r.month_b), int'(r.day_b)))) begin
            res.status = STAT_BAD_DATE;
        end else if (r.op == OP_ADD || r.op == OP_SUB) begin
            if (years) begin
                y = (r.op == OP_ADD) ? y + int'(r.amount) : y - int'(r.amount);
                if (y < 1 || y > YEAR_TOP) begin
                    res.status = STAT_RANGE;
                end else if (d > month_days(m, y)) begin
                    d = month_days(m, y);  // Feb 29 lands in a common year
                end
            end else if (r.op == OP_ADD) begin
                d = d + int'(r.amount);
                while (d > month_days(m, y) && res.status == STAT_OK) begin
                    d -= month_days(m, y);
                    m++;
                    if (m > 12) begin
                        m = 1;
                        y++;
                        if (y > YEAR_TOP) res.status = STAT_RANGE;
                    end
                end
            end else begin
                left = int'(r.amount);
                while (left >= d && res.status == STAT_OK) begin
                    left -= d;
                    m--;
                    if (m < 1) begin
                        m = 12;
                        y--;
                        if (y < 1) res.status = STAT_RANGE;
                    end
                    d = month_days(m, y);
                end
                d -= left;
            end
            if (res.status == STAT_OK) begin
                res.res_year  = 14'(y);
                res.res_month = 4'(m);
                res.res_day   = 5'(d);
            end
        end else if (r.op == OP_DIFF) begin
            if (years) begin
                diff = int'(r.year_a) - int'(r.year_b);
                // anniversary not reached yet this year
                if (r.month_b > r.month_a || (r.month_b == r.month_a && r.day_b > r.day_a))
                    diff--;
            end else begin
                diff = serial_day(y, m, d) -
                       serial_day(int'(r.year_b), int'(r.month_b), int'(r.day_b));
            end
            res.difference  = diff[22:0];
            res.a_is_later  = {r.year_a, r.month_a, r.day_a} > {r.year_b, r.month_b, r.day_b};
            res.dates_equal = {r.year_a, r.month_a, r.day_a} == {r.year_b, r.month_b, r.day_b};
        end else begin
            yy   = y % 100;
            cent = (3 - (y / 100) % 4) * 2;
            mt   = WD_TAB[m - 1];
            if (leap_year(y) && m == 1) mt = 6;
            if (leap_year(y) && m == 2) mt = 2;
            res.weekday = 3'((cent + yy + yy / 4 + mt + d) % 7);
        end
        return res;
    endfunction

    function automatic date_res_t mk_res(t_status st, int y, int m, int d, int diff,
                                         bit later, bit eq, int wd);
        date_res_t res;
        res.status      = st;
        res.res_year    = 14'(y);
        res.res_month   = 4'(m);
        res.res_day     = 5'(d);
        res.difference  = 23'(diff);
        res.a_is_later  = later;
        res.dates_equal = eq;
        res.weekday     = 3'(wd);
        return res;
    endfunction

    function automatic string fmt_res(date_res_t x);
        return $sformatf("st=%0d date=%0d-%0d-%0d diff=%0d later=%0b eq=%0b wd=%0d",
                         x.status, x.res_year, x.res_month, x.res_day,
                         $signed(x.difference), x.a_is_later, x.dates_equal, x.weekday);
    endfunction

    // ---------------- stimulus helpers ----------------

    function automatic int idle_cycles();
        int k;
        k = $urandom_range(0, 99);
        if (k < 55) return 0;
        if (k < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic add_row(input bit mode, input t_op op, input int ya, input int ma,
                           input int da, input int yb, input int mb, input int db,
                           input int amt, input bit typed, input date_res_t res);
        dir_row_t row;
        row.mode        = mode;
        row.req.op      = op;
        row.req.year_a  = 14'(ya);
        row.req.month_a = 4'(ma);
        row.req.day_a   = 5'(da);
        row.req.year_b  = 14'(yb);
        row.req.month_b = 4'(mb);
        row.req.day_b   = 5'(db);
        row.req.amount  = AMOUNT_W'(amt);
        row.typed       = typed;
        row.res         = res;
        dir_tab.push_back(row);
    endtask

    task automatic pick_date(output int y, output int m, output int d);
        case ($urandom_range(0, 7))
            0: y = $urandom_range(1, 4);
            1: y = $urandom_range(9990, 9999);
            2: y = 100 * $urandom_range(1, 99);  // century rule
            default: y = $urandom_range(1, 9999);
        endcase
        m = $urandom_range(1, 12);
        if ($urandom_range(0, 3) == 0) d = month_days(m, y);
        else d = $urandom_range(1, month_days(m, y));
    endtask

    task automatic rand_request(output date_req_t r);
        int y, m, d, yb, mb, db, k;
        r.op = t_op'($urandom_range(0, 3));
        if ($urandom_range(0, 99) < 10) begin
            // raw fields, mostly bad dates
            r.year_a  = 14'($urandom_range(0, 16383));
            r.month_a = 4'($urandom_range(0, 15));
            r.day_a   = 5'($urandom_range(0, 31));
            r.year_b  = 14'($urandom_range(0, 16383));
            r.month_b = 4'($urandom_range(0, 15));
            r.day_b   = 5'($urandom_range(0, 31));
            r.amount  = AMOUNT_W'($urandom_range(0, 65535));
        end else begin
            pick_date(y, m, d);
            pick_date(yb, mb, db);
            case ($urandom_range(0, 3))
                0: begin
                    yb = y;
                    mb = m;
                    db = d;
                end
                1: begin
                    mb = m;
                    db = d;
                end
                2: begin
                    mb = m;
                    db = $urandom_range(1, month_days(m, yb));
                end
                default: begin
                end
            endcase
            r.year_a  = 14'(y);
            r.month_a = 4'(m);
            r.day_a   = 5'(d);
            r.year_b  = 14'(yb);
            r.month_b = 4'(mb);
            r.day_b   = 5'(db);
            k = $urandom_range(0, 99);
            if (k < 70)
                r.amount = AMOUNT_W'(arith_mode_q ? $urandom_range(0, 50)
                                                  : $urandom_range(0, 400));
            else if (k < 92)
                r.amount = AMOUNT_W'(arith_mode_q ? $urandom_range(0, 9999)
                                                  : $urandom_range(0, 4000));
            else
                r.amount = AMOUNT_W'($urandom_range(0, 65535));
        end
    endtask

    // Caller sits just after the previous acceptance; valid stays up on zero gap.
    task automatic issue_req(input date_req_t r, input int gap, input bit typed,
                             input date_res_t typed_res);
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, r.amount, r.day_b, r.month_b, r.year_b,
                          r.day_a, r.month_a, r.year_a};
        s_axis_tuser  <= r.op;
        do @(posedge i_clk); while (!s_axis_tready);
        due_results.push_back(typed ? typed_res : compute_date_op(arith_mode_q, r));
    endtask

    // Mode changes only with the core drained.
    task automatic set_arith_mode(input bit v);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        arith_mode_q = v;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // ---------------- main sequence ----------------

    initial begin
        date_req_t r;
        date_res_t bad, rng, none;
        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = OP_ADD;
        i_cfg_valid    = 1'b0;
        i_cfg_data     = 1'b0;
        arith_mode_q   = 1'b0;
        drain_hold_req = 1'b0;
        n_mismatch     = 0;

        bad  = mk_res(STAT_BAD_DATE, 0, 0, 0, 0, 0, 0, 0);
        rng  = mk_res(STAT_RANGE, 0, 0, 0, 0, 0, 0, 0);
        none = '0;

        // day arithmetic
        add_row(0, OP_ADD, 1, 1, 1, 0, 0, 0, 0, 1, mk_res(STAT_OK, 1, 1, 1, 0, 0, 0, 0));
        add_row(0, OP_ADD, 9999, 12, 31, 0, 0, 0, 1, 1, rng);
        add_row(0, OP_SUB, 1, 1, 1, 0, 0, 0, 1, 1, rng);
        add_row(0, OP_ADD, 2024, 2, 28, 0, 0, 0, 1, 1,
                mk_res(STAT_OK, 2024, 2, 29, 0, 0, 0, 0));
        add_row(0, OP_ADD, 1900, 2, 28, 0, 0, 0, 1, 1,
                mk_res(STAT_OK, 1900, 3, 1, 0, 0, 0, 0));
        add_row(0, OP_ADD, 2000, 1, 31, 0, 0, 0, 65535, 0, none);
        add_row(0, OP_SUB, 9999, 12, 31, 0, 0, 0, 65535, 0, none);
        add_row(0, OP_SUB, 2000, 3, 1, 0, 0, 0, 1, 1,
                mk_res(STAT_OK, 2000, 2, 29, 0, 0, 0, 0));
        add_row(0, OP_DIFF, 9999, 12, 31, 1, 1, 1, 0, 0, none);
        add_row(0, OP_DIFF, 1, 1, 1, 9999, 12, 31, 0, 0, none);
        add_row(0, OP_DIFF, 2020, 5, 17, 2020, 5, 17, 0, 1,
                mk_res(STAT_OK, 0, 0, 0, 0, 0, 1, 0));
        add_row(0, OP_WEEKDAY, 2000, 1, 1, 0, 0, 0, 0, 1,
                mk_res(STAT_OK, 0, 0, 0, 0, 0, 0, 6));
        add_row(0, OP_WEEKDAY, 9999, 12, 31, 0, 0, 0, 0, 0, none);
        add_row(0, OP_WEEKDAY, 1, 1, 1, 0, 0, 0, 0, 0, none);
        // bad dates
        add_row(0, OP_ADD, 2001, 2, 29, 0, 0, 0, 5, 1, bad);
        add_row(0, OP_SUB, 2000, 0, 10, 0, 0, 0, 5, 1, bad);
        add_row(0, OP_WEEKDAY, 2000, 5, 0, 0, 0, 0, 0, 1, bad);
        add_row(0, OP_DIFF, 2020, 1, 1, 2020, 13, 1, 0, 1, bad);
        add_row(0, OP_ADD, 0, 6, 15, 0, 0, 0, 1, 1, bad);
        add_row(0, OP_WEEKDAY, 16383, 15, 31, 16383, 15, 31, 65535, 1, bad);
        // year arithmetic
        add_row(1, OP_ADD, 2000, 2, 29, 0, 0, 0, 1, 1,
                mk_res(STAT_OK, 2001, 2, 28, 0, 0, 0, 0));
        add_row(1, OP_SUB, 2000, 2, 29, 0, 0, 0, 4, 1,
                mk_res(STAT_OK, 1996, 2, 29, 0, 0, 0, 0));
        add_row(1, OP_ADD, 9999, 1, 1, 0, 0, 0, 1, 1, rng);
        add_row(1, OP_SUB, 5, 6, 15, 0, 0, 0, 5, 1, rng);
        add_row(1, OP_DIFF, 2020, 3, 10, 2000, 3, 11, 0, 1,
                mk_res(STAT_OK, 0, 0, 0, 19, 1, 0, 0));
        add_row(1, OP_ADD, 1, 1, 1, 0, 0, 0, 65535, 1, rng);

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        set_arith_mode(1'b0);

        foreach (dir_tab[i]) begin
            if (dir_tab[i].mode != arith_mode_q) set_arith_mode(dir_tab[i].mode);
            issue_req(dir_tab[i].req, idle_cycles(), dir_tab[i].typed, dir_tab[i].res);
        end

        for (int phase = 0; phase < 4; phase++) begin
            set_arith_mode(phase[0]);
            if (phase == 1) begin
                // result side holds off while requests keep coming back to back
                drain_hold_req = 1'b1;
                repeat (12) begin
                    rand_request(r);
                    r.amount = AMOUNT_W'($urandom_range(0, 20));
                    issue_req(r, 0, 1'b0, none);
                end
            end
            repeat (60) begin
                rand_request(r);
                issue_req(r, (phase == 2) ? 0 : idle_cycles(), 1'b0, none);
            end
        end

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (n_mismatch == 0) begin
            $display("calendar_date_arithmetic_unit_core regression: pass");
        end else begin
            $display("calendar_date_arithmetic_unit_core regression: fail");
        end
        $finish;
    end

    // ---------------- result side ----------------

    initial begin
        int n;
        m_axis_tready = 1'b0;
        wait (i_rst_n == 1'b1);
        @(negedge i_clk);
        forever begin
            if (drain_hold_req) begin
                drain_hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (400) @(negedge i_clk);
            end else begin
                n = idle_cycles();
                if (n > 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (n) @(negedge i_clk);
                end
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        date_res_t got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.res_year    = m_axis_tdata[13:0];
            got.res_month   = m_axis_tdata[17:14];
            got.res_day     = m_axis_tdata[22:18];
            got.difference  = m_axis_tdata[45:23];
            got.a_is_later  = m_axis_tdata[46];
            got.dates_equal = m_axis_tdata[47];
            got.weekday     = m_axis_tdata[50:48];
            got.status      = t_status'(m_axis_tuser);
            if (due_results.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("ERROR %0t: result with no request pending: %s",
                             $time, fmt_res(got));
            end else begin
                want = due_results.pop_front();
                if (got != want) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("ERROR %0t: result mismatch\n  exp %s\n  got %s",
                                 $time, fmt_res(want), fmt_res(got));
                end
            end
        end
    end

    initial begin
        #30_000_000;
        $display("calendar_date_arithmetic_unit_core regression: fail");
        $finish;
    end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/cdau_pkg.sv
hw/rtl/cdau_alu.sv
hw/rtl/calendar_date_arithmetic_unit_core.sv
dv/tb_top.sv
